@@ rtl/bdq_pkg.sv @@
// Package for the bounded double-ended queue with search.
// Holds field widths, request kind codes, status codes, the internal command
// format and the channel payload structs. Depends on nothing.
package bdq_pkg;

	localparam int CAPACITY_DEF = 256;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;
	localparam int TOTAL_W  = 40;

	// Request kinds as they arrive on the request channel.
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_COUNT      = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SUM        = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd6;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Internal operation after classification.
	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_COUNT,
		OP_SUM,
		OP_SEARCH,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic signed [VALUE_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0]          kind;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]        status;
		logic [COUNT_W-1:0]         element_count;
		logic [COUNT_W-1:0]         position;
		logic signed [TOTAL_W-1:0]  total;
	} rsp_t;

	typedef enum logic {
		BK_IDLE,
		BK_WALK
	} back_state_t;

endpackage

@@ rtl/bdq_if.sv @@
// Valid/ready channel interfaces for the request and result channels.
// Depends on bdq_pkg for the payload structs.
interface bdq_req_if;
	logic          valid;
	logic          ready;
	bdq_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bdq_rsp_if;
	logic          valid;
	logic          ready;
	bdq_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bounded_deque_with_search.sv @@
// Top level of the bounded double-ended queue with search.
// Depends on bdq_pkg, bdq_if, bdq_front, bdq_back (and bdq_ram through it).
//
// Usage: requests enter on the req channel (kind, value) and every request
// gives exactly one transaction on the rsp channel (status, element_count,
// position, total), in request order. Both channels are valid/ready; a
// transaction completes at a rising edge with valid and ready both high.
// The front end classifies each request and parks it in a two-entry command
// queue, so req keeps accepting while the back end is busy or while a result
// waits on rsp. Pushes, pops, counts and the unused kind need no walk; the
// back end retires one per cycle while rsp is free or its result is taken. Sums
// and searches of a non-empty queue walk the ring through the single read
// port of the element store, a search stops after the first match is read,
// and no further command starts meanwhile.
// Reset (arst_n low) empties the queue: front index and occupancy go to zero
// and both channels go idle; the store itself is not cleared, since only
// live entries are ever read. When the receiver holds rsp.ready low, the
// result stays registered, the back end stops taking commands, and once the
// command queue fills, req.ready drops until the result is taken.
module bounded_deque_with_search #(
	parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bdq_req_if.sink    req,
	bdq_rsp_if.source  rsp
);

	logic          cmd_valid;
	logic          cmd_pop;
	bdq_pkg::cmd_t cmd;

	bdq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	bdq_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);

endmodule

@@ rtl/bdq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; contents are undefined until written.
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/bdq_front.sv @@
// Front end: accepts requests, classifies them into commands and holds them
// in a two-entry command queue for the back end. Depends on bdq_pkg, bdq_if.
module bdq_front (
	input  logic           clk,
	input  logic           arst_n,
	bdq_req_if.sink        req,
	output logic           cmd_valid,
	output bdq_pkg::cmd_t  cmd,
	input  logic           cmd_pop
);

	bdq_pkg::cmd_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	bdq_pkg::cmd_t cls;
	logic          push;

	// Map the request kind to an operation.
	always_comb begin
		cls.value = req.data.value;
		case (req.data.kind)
			bdq_pkg::KIND_PUSH_FRONT: cls.op = bdq_pkg::OP_PUSH_FRONT;
			bdq_pkg::KIND_PUSH_BACK:  cls.op = bdq_pkg::OP_PUSH_BACK;
			bdq_pkg::KIND_POP_FRONT:  cls.op = bdq_pkg::OP_POP_FRONT;
			bdq_pkg::KIND_POP_BACK:   cls.op = bdq_pkg::OP_POP_BACK;
			bdq_pkg::KIND_COUNT:      cls.op = bdq_pkg::OP_COUNT;
			bdq_pkg::KIND_SUM:        cls.op = bdq_pkg::OP_SUM;
			bdq_pkg::KIND_SEARCH:     cls.op = bdq_pkg::OP_SEARCH;
			default:                  cls.op = bdq_pkg::OP_NOP;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/bdq_back.sv @@
// Back end: owns the ring state and the element store, executes commands and
// walks the store for sums and searches. Depends on bdq_pkg and bdq_ram.
module bdq_back #(
	parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  bdq_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	bdq_rsp_if.source      rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = bdq_pkg::TOTAL_W - bdq_pkg::VALUE_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [CNT_W:0]   CAP_WIDE = (CNT_W + 1)'(CAPACITY);

	bdq_pkg::back_state_t state_q, state_d;
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] occ_q, occ_d;

	// Walk state.
	bdq_pkg::op_t                      op_q;
	logic signed [bdq_pkg::VALUE_W-1:0] key_q;
	logic [IDX_W-1:0]                  walk_addr_q;
	logic [CNT_W-1:0]                  i_q;
	logic                              found_q;
	logic [bdq_pkg::COUNT_W-1:0]       pos_q;
	logic signed [bdq_pkg::TOTAL_W-1:0] acc_q;
	logic                              rd_vld_s1;
	logic [CNT_W-1:0]                  idx_s1;

	logic                              rsp_valid_q;
	bdq_pkg::rsp_t                     rsp_q, rsp_d;
	logic                              rsp_load;

	logic             out_free, full, empty, start_walk, issue, walk_done;
	logic [IDX_W-1:0] front_dec, front_inc, back_slot, addr_next;
	logic [CNT_W:0]   back_sum;
	logic [CNT_W-1:0] idx_inc;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [bdq_pkg::VALUE_W-1:0] rd_data;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign cmd_pop  = (state_q == bdq_pkg::BK_IDLE) && cmd_valid && out_free;
	assign full     = (occ_q == CNT_FULL);
	assign empty    = (occ_q == '0);

	assign front_dec = (front_q == '0) ? IDX_LAST : front_q - 1'b1;
	assign front_inc = (front_q == IDX_LAST) ? '0 : front_q + 1'b1;
	assign back_sum  = (CNT_W + 1)'(front_q) + (CNT_W + 1)'(occ_q);
	assign back_slot = (back_sum >= CAP_WIDE) ? IDX_W'(back_sum - CAP_WIDE)
	                                          : IDX_W'(back_sum);
	assign addr_next = (walk_addr_q == IDX_LAST) ? '0 : walk_addr_q + 1'b1;
	assign idx_inc   = idx_s1 + 1'b1;

	assign we    = cmd_pop && !full &&
	               (cmd.op == bdq_pkg::OP_PUSH_FRONT || cmd.op == bdq_pkg::OP_PUSH_BACK);
	assign waddr = (cmd.op == bdq_pkg::OP_PUSH_FRONT) ? front_dec : back_slot;

	assign issue     = (i_q != occ_q) && !found_q;
	assign walk_done = found_q || ((i_q == occ_q) && !rd_vld_s1);

	bdq_ram #(
		.WIDTH (bdq_pkg::VALUE_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cmd.value),
		.raddr (walk_addr_q),
		.rdata (rd_data)
	);

	always_comb begin
		state_d    = state_q;
		front_d    = front_q;
		occ_d      = occ_q;
		start_walk = 1'b0;
		rsp_load   = 1'b0;
		rsp_d.status        = bdq_pkg::ST_OK;
		rsp_d.position      = '0;
		rsp_d.total         = '0;
		rsp_d.element_count = '0;
		case (state_q)
			bdq_pkg::BK_IDLE: begin
				if (cmd_pop) begin
					rsp_load = 1'b1;
					case (cmd.op)
						bdq_pkg::OP_PUSH_FRONT: begin
							if (full) begin
								rsp_d.status = bdq_pkg::ST_FULL;
							end else begin
								front_d = front_dec;
								occ_d   = occ_q + 1'b1;
							end
						end
						bdq_pkg::OP_PUSH_BACK: begin
							if (full) begin
								rsp_d.status = bdq_pkg::ST_FULL;
							end else begin
								occ_d = occ_q + 1'b1;
							end
						end
						bdq_pkg::OP_POP_FRONT: begin
							if (empty) begin
								rsp_d.status = bdq_pkg::ST_EMPTY;
							end else begin
								front_d = front_inc;
								occ_d   = occ_q - 1'b1;
							end
						end
						bdq_pkg::OP_POP_BACK: begin
							if (empty) begin
								rsp_d.status = bdq_pkg::ST_EMPTY;
							end else begin
								occ_d = occ_q - 1'b1;
							end
						end
						bdq_pkg::OP_SUM,
						bdq_pkg::OP_SEARCH: begin
							if (empty) begin
								if (cmd.op == bdq_pkg::OP_SEARCH) begin
									rsp_d.status = bdq_pkg::ST_EMPTY;
								end
							end else begin
								rsp_load   = 1'b0;
								start_walk = 1'b1;
								state_d    = bdq_pkg::BK_WALK;
							end
						end
						default: ;
					endcase
					rsp_d.element_count = bdq_pkg::COUNT_W'(occ_d);
				end
			end
			bdq_pkg::BK_WALK: begin
				if (walk_done) begin
					rsp_load            = 1'b1;
					state_d             = bdq_pkg::BK_IDLE;
					rsp_d.element_count = bdq_pkg::COUNT_W'(occ_q);
					if (op_q == bdq_pkg::OP_SEARCH) begin
						rsp_d.status   = found_q ? bdq_pkg::ST_OK : bdq_pkg::ST_NOT_FOUND;
						rsp_d.position = pos_q;
					end else begin
						rsp_d.total = acc_q;
					end
				end
			end
			default: state_d = bdq_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdq_pkg::BK_IDLE;
			front_q     <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
			i_q         <= '0;
			found_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			occ_q   <= occ_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (start_walk) begin
				i_q       <= '0;
				found_q   <= 1'b0;
				rd_vld_s1 <= 1'b0;
			end else if (state_q == bdq_pkg::BK_WALK) begin
				if (issue) begin
					i_q <= i_q + 1'b1;
				end
				rd_vld_s1 <= issue && !walk_done;
				if (rd_vld_s1 && !found_q && op_q == bdq_pkg::OP_SEARCH &&
				    rd_data == key_q) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		if (start_walk) begin
			op_q        <= cmd.op;
			key_q       <= cmd.value;
			walk_addr_q <= front_q;
			acc_q       <= '0;
			pos_q       <= '0;
		end else if (state_q == bdq_pkg::BK_WALK) begin
			if (issue) begin
				walk_addr_q <= addr_next;
				idx_s1      <= i_q;
			end
			if (rd_vld_s1 && !found_q) begin
				acc_q <= acc_q + {{EXT_W{rd_data[bdq_pkg::VALUE_W-1]}}, rd_data};
				if (op_q == bdq_pkg::OP_SEARCH && rd_data == key_q) begin
					pos_q <= bdq_pkg::COUNT_W'(idx_inc);
				end
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

@@ tb/bdq_result_checker.sv @@
// Scoreboard for the bounded double-ended queue with search.
// Watches the request and result channels, keeps its own copy of the ring and
// checks every result transaction. Depends on bdq_pkg and bdq_if.
module bdq_result_checker
	import bdq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bdq_req_if   req,
	bdq_rsp_if   rsp,
	output int   mismatch_count,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [VALUE_W-1:0] ring_store [CAPACITY];
	int unsigned        head_slot;
	int unsigned        live_count;
	rsp_t               pending_results [$];
	rsp_t               expected_rsp;

	// Applies one request to the shadow ring and returns the result it must give.
	function automatic rsp_t apply_request(req_t r);
		rsp_t                      res;
		logic signed [TOTAL_W-1:0] acc;
		logic signed [VALUE_W-1:0] elem;
		bit                        found;
		res   = '0;
		acc   = '0;
		found = 1'b0;
		case (r.kind)
			KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
				if (live_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else if (r.kind == KIND_PUSH_FRONT) begin
					head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
					ring_store[head_slot] = r.value;
					live_count++;
				end else begin
					ring_store[(head_slot + live_count) % CAPACITY] = r.value;
					live_count++;
				end
			end
			KIND_POP_FRONT: begin
				if (live_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					head_slot = (head_slot + 1) % CAPACITY;
					live_count--;
				end
			end
			KIND_POP_BACK: begin
				if (live_count == 0)
					res.status = ST_EMPTY;
				else
					live_count--;
			end
			KIND_SUM: begin
				for (int i = 0; i < live_count; i++) begin
					elem = ring_store[(head_slot + i) % CAPACITY];
					acc  = acc + elem;
				end
				res.total = acc;
			end
			KIND_SEARCH: begin
				if (live_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.status = ST_NOT_FOUND;
					for (int i = 0; i < live_count && !found; i++) begin
						if (ring_store[(head_slot + i) % CAPACITY] == r.value) begin
							found        = 1'b1;
							res.status   = ST_OK;
							res.position = COUNT_W'(i + 1);
						end
					end
				end
			end
			default: begin
			end
		endcase
		res.element_count = COUNT_W'(live_count);
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < 50)
			$display("%0t ns: mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_slot      = 0;
			live_count     = 0;
			mismatch_count = 0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result transaction with no request outstanding");
				end else begin
					expected_rsp = pending_results.pop_front();
					if (rsp.data.status !== expected_rsp.status)
						report_mismatch($sformatf("status expected %0d, got %0d",
							expected_rsp.status, rsp.data.status));
					if (rsp.data.element_count !== expected_rsp.element_count)
						report_mismatch($sformatf("element_count expected %0d, got %0d",
							expected_rsp.element_count, rsp.data.element_count));
					if (rsp.data.position !== expected_rsp.position)
						report_mismatch($sformatf("position expected %0d, got %0d",
							expected_rsp.position, rsp.data.position));
					if (rsp.data.total !== expected_rsp.total)
						report_mismatch($sformatf("total expected %0d, got %0d",
							expected_rsp.total, rsp.data.total));
				end
			end
			if (req.valid && req.ready)
				pending_results.push_back(apply_request(req.data));
			outstanding <= pending_results.size();
		end
	end

endmodule

@@ tb/tb_bounded_deque_with_search.sv @@
// Top of the testbench for the bounded double-ended queue with search.
// Generates request traffic and result back-pressure and gives the verdict.
// Depends on bdq_pkg, bdq_if, bdq_result_checker and the block itself.
module tb_bounded_deque_with_search;
	timeunit 1ns;
	timeprecision 1ps;
	import bdq_pkg::*;

	// The request kind that the block treats as a no-operation.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

	// Shapes of random traffic: filling pushes the queue up to full and beyond,
	// draining pops it past empty, and mixed keeps the level wandering.
	typedef enum int {
		EP_FILL,
		EP_DRAIN,
		EP_MIXED
	} episode_t;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   outstanding;
	int   burst_left;
	int   ready_mode;
	int   ready_left;
	int   random_sent;

	logic [VALUE_W-1:0] value_pool [16];

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	bounded_deque_with_search #(
		.CAPACITY (CAPACITY_DEF)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// The checker sits beside the block and sees the same channel wires.
	bdq_result_checker #(
		.CAPACITY (CAPACITY_DEF)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result back-pressure. The receiver switches at random between three habits:
	// always ready, ready half the time, or stalling most of the time.
	// This pattern is independent of the sender, so stalls land on every phase
	// of the block's work, including the middle of long sum and search walks.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			ready_mode = 0;
			ready_left = 0;
		end else begin
			if (ready_left == 0) begin
				ready_mode = $urandom_range(0, 2);
				ready_left = $urandom_range(10, 60);
			end
			ready_left--;
			case (ready_mode)
				0:       rsp_ch.ready <= 1'b1;
				1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// Values are drawn half of the time from a small pool so that searches hit often and
	// duplicates appear, with the sign extremes and fully random words mixed in
	// so that every bit of the value field toggles.
	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 15);
		if (r < 2) begin
			case ($urandom_range(0, 3))
				0:       return 32'h7FFF_FFFF;
				1:       return 32'h8000_0000;
				2:       return 32'hFFFF_FFFF;
				default: return 32'h0000_0000;
			endcase
		end else if (r < 10) begin
			return value_pool[$urandom_range(0, 15)];
		end
		return $urandom;
	endfunction

	// Requests that leave the level alone: count, sum, search and the unused kind.
	function automatic logic [KIND_W-1:0] pick_query();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return KIND_COUNT;
		else if (r < 5)
			return KIND_SUM;
		else if (r < 9)
			return KIND_SEARCH;
		return KIND_UNUSED;
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind(episode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			EP_FILL: begin
				if (r < 90)
					return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
			end
			EP_DRAIN: begin
				if (r < 90)
					return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
			end
			default: begin
				if (r < 30)
					return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
				else if (r < 60)
					return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
			end
		endcase
		return pick_query();
	endfunction

	// Sends one request and returns at the edge where the transaction completed.
	// Requests go out in bursts; between bursts the sender may drop valid for a
	// while. Within a burst valid stays high and only the payload changes, so
	// valid is never lowered and raised in the same time step.
	task automatic send_req(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value);
		int   gap;
		req_t item;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 16);
		end
		burst_left--;
		item.kind  = kind;
		item.value = value;
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic run_episode(episode_t mode, int count);
		for (int n = 0; n < count; n++)
			send_req(pick_kind(mode), pick_value());
		random_sent += count;
	endtask

	initial begin
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		burst_left  = 0;
		random_sent = 0;
		foreach (value_pool[i])
			value_pool[i] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Start on an empty queue: pops and a search must report
		// empty, while count, sum and the unused kind still succeed with zeros.
		send_req(KIND_POP_FRONT, 32'h0000_0000);
		send_req(KIND_POP_BACK, 32'hFFFF_FFFF);
		send_req(KIND_SEARCH, 32'h0000_0000);
		send_req(KIND_COUNT, 32'h0000_0000);
		send_req(KIND_SUM, 32'h0000_0000);
		send_req(KIND_UNUSED, 32'h1234_5678);

		// Build front to back: min, min, max, max, -1, 0, with duplicates so a
		// search has to report the first match from the front.
		send_req(KIND_PUSH_BACK, 32'h7FFF_FFFF);
		send_req(KIND_PUSH_BACK, 32'h7FFF_FFFF);
		send_req(KIND_PUSH_FRONT, 32'h8000_0000);
		send_req(KIND_PUSH_FRONT, 32'h8000_0000);
		send_req(KIND_PUSH_BACK, 32'hFFFF_FFFF);
		send_req(KIND_PUSH_BACK, 32'h0000_0000);
		send_req(KIND_SUM, 32'h0000_0000);
		send_req(KIND_COUNT, 32'h0000_0000);
		send_req(KIND_SEARCH, 32'h8000_0000);
		send_req(KIND_SEARCH, 32'h7FFF_FFFF);
		send_req(KIND_SEARCH, 32'h0000_0000);
		send_req(KIND_SEARCH, 32'd12345);
		send_req(KIND_UNUSED, 32'hFFFF_FFFF);

		// Remove one from each end and look again.
		send_req(KIND_POP_FRONT, 32'h0000_0000);
		send_req(KIND_POP_BACK, 32'h0000_0000);
		send_req(KIND_SEARCH, 32'hFFFF_FFFF);
		send_req(KIND_SUM, 32'h0000_0000);

		// Random part. One deliberate climb past full, so pushes get refused and
		// the ring index wraps, then a fall past empty; after that, episodes of
		// random shape and length.
		run_episode(EP_FILL, 380);
		run_episode(EP_DRAIN, 380);
		while (random_sent < 2000) begin
			case ($urandom_range(0, 3))
				0:       run_episode(EP_FILL, $urandom_range(30, 200));
				1:       run_episode(EP_DRAIN, $urandom_range(30, 200));
				default: run_episode(EP_MIXED, $urandom_range(30, 200));
			endcase
		end
		req_ch.valid <= 1'b0;

		// The checker counts the last request's expectation in a registered value,
		// so step at least once before testing for an empty scoreboard.
		do @(posedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog: far beyond even a run where every request is a full-queue sum
	// behind the longest receiver stalls.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_ram.sv
rtl/bdq_front.sv
rtl/bdq_back.sv
rtl/bounded_deque_with_search.sv
tb/bdq_result_checker.sv
tb/tb_bounded_deque_with_search.sv
